// File: rtl/core/mirf_pkg.sv
// Package for the masked IP rule filter.
// Holds the table size, opcodes, status codes and the token passed along the cell chain.
// No dependencies.
`default_nettype none

package mirf_pkg;

  localparam int RULES_PER_DIRECTION = 16;

  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic        valid;
    logic        done;
    logic [1:0]  opcode;
    logic        direction;
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
  } tok_t;

endpackage

`default_nettype wire

// File: rtl/core/masked_ip_rule_filter.sv
// A transaction is loaded into the first cell when it is accepted, then moves through each
// further cell register in turn and finally through the output register.
// Throughput: one transaction per cycle; each transaction sees every update of earlier ones.
// A stalled output holding a valid result freezes the whole chain and stalls the input.
// Reset clears every rule valid bit and the chain; rule words are not reset.
// Top level of the masked IP rule filter; depends on mirf_pkg, mirf_cell and mirf_result.
`default_nettype none

module masked_ip_rule_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic        in_direction,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_src_mask,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [31:0] in_dst_mask,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_drop,
  output logic [1:0]       out_status
);

  mirf_pkg::tok_t tok_head;
  mirf_pkg::tok_t chain [mirf_pkg::RULES_PER_DIRECTION];
  logic           advance;

  always_comb begin
    tok_head           = '0;
    tok_head.valid     = in_valid;
    tok_head.done      = 1'b0;
    tok_head.opcode    = in_opcode;
    tok_head.direction = in_direction;
    tok_head.src_addr  = in_src_addr;
    tok_head.src_mask  = in_src_mask;
    tok_head.dst_addr  = in_dst_addr;
    tok_head.dst_mask  = in_dst_mask;
  end

  assign in_stall = !advance;

  for (genvar k = 0; k < mirf_pkg::RULES_PER_DIRECTION; k++) begin : g_cell
    if (k == 0) begin : g_first
      mirf_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tok_in  (tok_head),
        .tok_out (chain[k])
      );
    end else begin : g_rest
      mirf_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tok_in  (chain[k-1]),
        .tok_out (chain[k])
      );
    end
  end

  mirf_result u_result (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_last   (chain[mirf_pkg::RULES_PER_DIRECTION-1]),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_drop   (out_drop),
    .out_status (out_status)
  );

`ifndef SYNTHESIS
  a_drop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drop) |-> (out_status == mirf_pkg::ST_OK))
    else $error("drop with non-ok status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == mirf_pkg::ST_OK || out_status == mirf_pkg::ST_FULL ||
                   out_status == mirf_pkg::ST_NOT_FOUND))
    else $error("undefined status code");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> $past(chain[mirf_pkg::RULES_PER_DIRECTION-1].valid))
    else $error("result without a token leaving the chain");

  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(chain[mirf_pkg::RULES_PER_DIRECTION-1]))
    else $error("chain moved while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mirf_cell.sv
// One cell of the rule chain: one inbound and one outbound rule slot.
// Applies the passing transaction to its slots and hands the token on.
// Depends on mirf_pkg.
`default_nettype none

module mirf_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  input  wire mirf_pkg::tok_t tok_in,
  output mirf_pkg::tok_t     tok_out
);

  logic [1:0]  valid_r;
  logic [1:0]  valid_nxt;
  logic [31:0] src_addr_r [2];
  logic [31:0] src_mask_r [2];
  logic [31:0] dst_addr_r [2];
  logic [31:0] dst_mask_r [2];
  mirf_pkg::tok_t tok_r;
  mirf_pkg::tok_t tok_nxt;
  logic        d;
  logic        s_ok;
  logic        d_ok;
  logic        same;
  logic        wr_en;

  always_comb begin
    d     = tok_in.direction;
    s_ok  = (src_addr_r[d] == 32'd0) ||
            (((tok_in.src_addr ^ src_addr_r[d]) & src_mask_r[d]) == 32'd0);
    d_ok  = (dst_addr_r[d] == 32'd0) ||
            (((tok_in.dst_addr ^ dst_addr_r[d]) & dst_mask_r[d]) == 32'd0);
    same  = (src_addr_r[d] == tok_in.src_addr) && (src_mask_r[d] == tok_in.src_mask) &&
            (dst_addr_r[d] == tok_in.dst_addr) && (dst_mask_r[d] == tok_in.dst_mask);
    tok_nxt   = tok_in;
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    if (tok_in.valid && !tok_in.done) begin
      case (tok_in.opcode)
        mirf_pkg::OP_FILTER: begin
          if (valid_r[d] && s_ok && d_ok) begin
            tok_nxt.done = 1'b1;
          end
        end
        mirf_pkg::OP_ADD: begin
          if (!valid_r[d]) begin
            valid_nxt[d] = 1'b1;
            wr_en        = 1'b1;
            tok_nxt.done = 1'b1;
          end
        end
        mirf_pkg::OP_REMOVE: begin
          if (valid_r[d] && same) begin
            valid_nxt[d] = 1'b0;
            tok_nxt.done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      tok_r   <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      src_addr_r[d] <= tok_in.src_addr;
      src_mask_r[d] <= tok_in.src_mask;
      dst_addr_r[d] <= tok_in.dst_addr;
      dst_mask_r[d] <= tok_in.dst_mask;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

// File: rtl/core/mirf_result.sv
// Output stage of the rule filter: turns the token leaving the chain into drop and status.
// Holds the result register and derives the chain advance enable.
// Depends on mirf_pkg.
`default_nettype none

module mirf_result (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mirf_pkg::tok_t tok_last,
  input  wire logic           out_stall,
  output logic                advance,
  output logic                out_valid,
  output logic                out_drop,
  output logic [1:0]          out_status
);

  logic       out_valid_r;
  logic       out_drop_r;
  logic [1:0] out_status_r;
  logic       drop_nxt;
  logic [1:0] status_nxt;

  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    drop_nxt   = 1'b0;
    status_nxt = mirf_pkg::ST_OK;
    case (tok_last.opcode)
      mirf_pkg::OP_FILTER: drop_nxt = tok_last.done;
      mirf_pkg::OP_ADD: begin
        if (!tok_last.done) begin
          status_nxt = mirf_pkg::ST_FULL;
        end
      end
      mirf_pkg::OP_REMOVE: begin
        if (!tok_last.done) begin
          status_nxt = mirf_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tok_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drop_r   <= drop_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_drop   = out_drop_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

// File: bench/tb_masked_ip_rule_filter.sv
`timescale 1ns / 100ps
// Self-checking bench for masked_ip_rule_filter: directed and random rule traffic with a
// rule-table predictor, random idling on both channels. Depends on mirf_pkg and the RTL.

module tb_masked_ip_rule_filter;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int TIMEOUT_NS = 4_000_000;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] src_mask;
    logic [31:0] dst_addr;
    logic [31:0] dst_mask;
  } rule_t;

  typedef struct packed {
    logic       drop;
    logic [1:0] status;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_opcode = mirf_pkg::OP_FILTER;
  logic        in_direction = 1'b0;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_src_mask = '0;
  logic [31:0] in_dst_addr = '0;
  logic [31:0] in_dst_mask = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_drop;
  logic [1:0]  out_status;

  bit       calm = 1'b0;
  int       errors = 0;
  bit       held [2][mirf_pkg::RULES_PER_DIRECTION];
  rule_t    rules [2][mirf_pkg::RULES_PER_DIRECTION];
  verdict_t pending_verdicts [$];

  masked_ip_rule_filter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_direction (in_direction),
    .in_src_addr  (in_src_addr),
    .in_src_mask  (in_src_mask),
    .in_dst_addr  (in_dst_addr),
    .in_dst_mask  (in_dst_mask),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drop     (out_drop),
    .out_status   (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit rule_covers(rule_t r, logic [31:0] sa, logic [31:0] da);
    return (r.src_addr == '0 || ((sa ^ r.src_addr) & r.src_mask) == '0) &&
           (r.dst_addr == '0 || ((da ^ r.dst_addr) & r.dst_mask) == '0);
  endfunction

  function automatic verdict_t screen_item(logic [1:0] op, logic dir, rule_t r);
    verdict_t v;
    bit       done;
    v = '0;
    done = 1'b0;
    case (op)
      mirf_pkg::OP_FILTER: begin
        for (int k = 0; k < mirf_pkg::RULES_PER_DIRECTION && !done; k++) begin
          if (held[dir][k] && rule_covers(rules[dir][k], r.src_addr, r.dst_addr)) begin
            v.drop = 1'b1;
            done = 1'b1;
          end
        end
      end
      mirf_pkg::OP_ADD: begin
        v.status = mirf_pkg::ST_FULL;
        for (int k = 0; k < mirf_pkg::RULES_PER_DIRECTION && !done; k++) begin
          if (!held[dir][k]) begin
            held[dir][k] = 1'b1;
            rules[dir][k] = r;
            v.status = mirf_pkg::ST_OK;
            done = 1'b1;
          end
        end
      end
      mirf_pkg::OP_REMOVE: begin
        v.status = mirf_pkg::ST_NOT_FOUND;
        for (int k = 0; k < mirf_pkg::RULES_PER_DIRECTION && !done; k++) begin
          if (held[dir][k] && rules[dir][k] == r) begin
            held[dir][k] = 1'b0;
            v.status = mirf_pkg::ST_OK;
            done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic int pick_slot(logic dir);
    int slots [$];
    for (int k = 0; k < mirf_pkg::RULES_PER_DIRECTION; k++) begin
      if (held[dir][k]) slots.push_back(k);
    end
    if (slots.size() == 0) return -1;
    return slots[$urandom_range(slots.size() - 1)];
  endfunction

  function automatic logic [31:0] make_addr();
    logic [7:0] octets [4] = '{8'h0a, 8'hc0, 8'hac, 8'hfe};
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return {octets[$urandom_range(3)], 16'($urandom_range(3)), 8'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] make_mask();
    int n;
    n = $urandom_range(1, 32);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return '1 << (32 - n);
    endcase
  endfunction

  function automatic rule_t make_rule();
    rule_t r;
    r.src_addr = make_addr();
    r.src_mask = make_mask();
    r.dst_addr = make_addr();
    r.dst_mask = make_mask();
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic dir, rule_t r);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_direction <= dir;
    in_src_addr  <= r.src_addr;
    in_src_mask  <= r.src_mask;
    in_dst_addr  <= r.dst_addr;
    in_dst_mask  <= r.dst_mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(screen_item(op, dir, r));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction drop=%0b status=%0d", $time, out_drop,
                 out_status);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_drop !== want.drop) begin
          errors++;
          $display("%0t: drop mismatch, expected %0b actual %0b", $time, want.drop, out_drop);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status,
                   out_status);
        end
      end
    end
    out_stall <= !calm && ($urandom_range(99) < 38);
  end

  task automatic test_empty_tables();
    send_item(mirf_pkg::OP_FILTER, 1'b0, '1);
    send_item(mirf_pkg::OP_FILTER, 1'b1, '0);
  endtask

  task automatic test_wildcard_rule();
    rule_t any_pkt;
    any_pkt = '{src_addr: '0, src_mask: '1, dst_addr: '0, dst_mask: '1};
    send_item(mirf_pkg::OP_ADD, 1'b1, any_pkt);
    send_item(mirf_pkg::OP_FILTER, 1'b1, '1);
    send_item(mirf_pkg::OP_FILTER, 1'b0, '1);
    send_item(mirf_pkg::OP_REMOVE, 1'b1, any_pkt);
    send_item(mirf_pkg::OP_REMOVE, 1'b1, any_pkt);
    send_item(mirf_pkg::OP_FILTER, 1'b1, '1);
  endtask

  task automatic test_exact_rule_and_duplicates();
    rule_t pkt;
    send_item(mirf_pkg::OP_ADD, 1'b0, '1);
    send_item(mirf_pkg::OP_FILTER, 1'b0, '1);
    pkt = '1;
    pkt.src_addr = 32'hffff_fffe;
    send_item(mirf_pkg::OP_FILTER, 1'b0, pkt);
    pkt = '1;
    pkt.dst_addr = 32'h7fff_ffff;
    send_item(mirf_pkg::OP_FILTER, 1'b0, pkt);
    send_item(mirf_pkg::OP_ADD, 1'b0, '1);
    send_item(mirf_pkg::OP_REMOVE, 1'b0, '1);
    send_item(mirf_pkg::OP_FILTER, 1'b0, '1);
    send_item(mirf_pkg::OP_REMOVE, 1'b0, '1);
    send_item(mirf_pkg::OP_FILTER, 1'b0, '1);
  endtask

  task automatic test_zero_masks();
    rule_t r;
    r = '{src_addr: 32'hc0a8_0001, src_mask: '0, dst_addr: 32'h0a00_0001, dst_mask: '0};
    send_item(mirf_pkg::OP_ADD, 1'b1, r);
    send_item(mirf_pkg::OP_FILTER, 1'b1, '0);
    send_item(mirf_pkg::OP_REMOVE, 1'b1, r);
  endtask

  task automatic test_reserved_opcode();
    send_item(OP_RESERVED, 1'b1, '1);
    send_item(mirf_pkg::OP_FILTER, 1'b1, '1);
  endtask

  task automatic random_item(int add_pct, int rem_pct);
    logic  dir;
    int    roll;
    int    slot;
    rule_t r;
    dir = 1'($urandom_range(1));
    roll = $urandom_range(99);
    slot = pick_slot(dir);
    if (roll < 3) begin
      r = {$urandom, $urandom, $urandom, $urandom};
      send_item(OP_RESERVED, dir, r);
    end else if (roll < 3 + add_pct) begin
      r = (slot >= 0 && $urandom_range(99) < 15) ? rules[dir][slot] : make_rule();
      send_item(mirf_pkg::OP_ADD, dir, r);
    end else if (roll < 3 + add_pct + rem_pct) begin
      if (slot >= 0 && $urandom_range(99) < 75) begin
        r = rules[dir][slot];
      end else if (slot >= 0 && $urandom_range(1) == 0) begin
        r = rules[dir][slot] ^ (128'd1 << $urandom_range(127));
      end else begin
        r = make_rule();
      end
      send_item(mirf_pkg::OP_REMOVE, dir, r);
    end else begin
      if (slot >= 0 && $urandom_range(99) < 60) begin
        r = rules[dir][slot];
        r.src_addr = r.src_addr ^ ($urandom & ~r.src_mask);
        r.dst_addr = r.dst_addr ^ ($urandom & ~r.dst_mask);
        if ($urandom_range(3) == 0) r.src_addr[$urandom_range(31)] ^= 1'b1;
        if ($urandom_range(3) == 0) r.dst_addr[$urandom_range(31)] ^= 1'b1;
      end else begin
        r.src_addr = make_addr();
        r.dst_addr = make_addr();
      end
      r.src_mask = $urandom;
      r.dst_mask = $urandom;
      send_item(mirf_pkg::OP_FILTER, dir, r);
    end
  endtask

  task automatic test_random_traffic();
    repeat (300) random_item(45, 10);
    calm = 1'b1;
    repeat (300) random_item(20, 20);
    calm = 1'b0;
    drain_results();
    repeat (300) random_item(10, 40);
    repeat (300) random_item(30, 25);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_tables();
    test_wildcard_rule();
    test_exact_rule_and_duplicates();
    test_zero_masks();
    test_reserved_opcode();
    drain_results();
    test_random_traffic();
    drain_results();
    repeat (mirf_pkg::RULES_PER_DIRECTION + 8) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("masked_ip_rule_filter test passed");
    end else begin
      $display("masked_ip_rule_filter test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("masked_ip_rule_filter test failed");
    $finish;
  end

endmodule
